>>> hw/rtl/rdt_pkg.sv
// shared types and constants for the report dedup table
package rdt_pkg;
  localparam int unsigned DataW = 8;
  localparam int unsigned CountW = 7;

  typedef enum logic [2:0] {
    DIR_NEUTRAL = 3'd0,
    DIR_UP      = 3'd1,
    DIR_DOWN    = 3'd2,
    DIR_LEFT    = 3'd3,
    DIR_RIGHT   = 3'd4,
    DIR_UNKNOWN = 3'd5
  } dir_e;

  typedef enum logic [0:0] {
    REG_AXIS_CENTER = 1'b0,
    REG_DEAD_ZONE   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_COPY,
    ST_RESULT
  } back_state_e;

  function automatic logic [DataW-1:0] abs_diff(input logic [DataW-1:0] v,
                                                input logic [DataW-1:0] c);
    abs_diff = (v >= c) ? v - c : c - v;
  endfunction

  function automatic dir_e classify(input logic [DataW-1:0] b1,
                                    input logic [DataW-1:0] b2,
                                    input logic [DataW-1:0] center,
                                    input logic [DataW-1:0] dz,
                                    input logic short_rep);
    logic [DataW-1:0] ax;
    logic [DataW-1:0] ay;
    ax = abs_diff(b1, center);
    ay = abs_diff(b2, center);
    if (short_rep) classify = DIR_UNKNOWN;
    else if (ax < dz && ay < dz) classify = DIR_NEUTRAL;
    else if (ax > ay) classify = (b1 > center) ? DIR_RIGHT : DIR_LEFT;
    else classify = (b2 > center) ? DIR_DOWN : DIR_UP;
  endfunction
endpackage

>>> hw/rtl/report_dedup_table_with_direction.sv
// top level of the report dedup table with direction classification
// input: one byte per cycle while the two-report queue has room; after the final byte the back
// end scans stored entries by length, compares the bytes of equal-length ones, and copies a new
// report into the table; each report holds the back end until its scan, any copy and its
// result hand-off are done
// reset: table empty, counts zero, axis_center 128, dead_zone 15; no clearing pass
module report_dedup_table_with_direction import rdt_pkg::*; #(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned MaxReportBytes = 65
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         report_byte_i,
  input  logic               final_byte_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [5:0]         entry_index_o,
  output logic               is_new_o,
  output logic               table_full_o,
  output logic [2:0]         direction_o,
  output logic [6:0]         stored_count_o,
  output logic [6:0]         count_up_o,
  output logic [6:0]         count_down_o,
  output logic [6:0]         count_left_o,
  output logic [6:0]         count_right_o,
  output logic [6:0]         count_rest_o
);
  localparam int unsigned LenW = $clog2(MaxReportBytes + 1);
  localparam int unsigned BAddrW = $clog2(2 * MaxReportBytes);
  localparam int unsigned EAddrW = $clog2(TableEntries * MaxReportBytes);

  logic [DataW-1:0] center_q, dz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= 8'd128;
      dz_q <= 8'd15;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_AXIS_CENTER: center_q <= cfg_data_i;
        REG_DEAD_ZONE: dz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic bwe, qvalid, qpop, qslot, ewe;
  logic [BAddrW-1:0] bwaddr, braddr;
  logic [DataW-1:0] bwdata, brdata, ewdata, erdata;
  logic [LenW-1:0] qlen;
  dir_e qdir;
  logic [EAddrW-1:0] ewaddr, eraddr;

  rdt_front #(.MaxBytes(MaxReportBytes)) u_front (
    .clk_i, .rst_ni, .report_byte_i, .final_byte_i, .valid_i, .ready_o,
    .axis_center_i(center_q), .dead_zone_i(dz_q),
    .bwe_o(bwe), .bwaddr_o(bwaddr), .bwdata_o(bwdata),
    .qvalid_o(qvalid), .qpop_i(qpop), .qslot_o(qslot), .qlen_o(qlen), .qdir_o(qdir)
  );

  rdt_ram #(.Width(DataW), .Depth(2 * MaxReportBytes)) u_buf (
    .clk_i, .we_i(bwe), .waddr_i(bwaddr), .wdata_i(bwdata),
    .raddr_i(braddr), .rdata_o(brdata)
  );

  rdt_ram #(.Width(DataW), .Depth(TableEntries * MaxReportBytes)) u_tab (
    .clk_i, .we_i(ewe), .waddr_i(ewaddr), .wdata_i(ewdata),
    .raddr_i(eraddr), .rdata_o(erdata)
  );

  rdt_back #(.Entries(TableEntries), .MaxBytes(MaxReportBytes)) u_back (
    .clk_i, .rst_ni, .qvalid_i(qvalid), .qpop_o(qpop), .qslot_i(qslot),
    .qlen_i(qlen), .qdir_i(qdir), .braddr_o(braddr), .brdata_i(brdata),
    .ewe_o(ewe), .ewaddr_o(ewaddr), .ewdata_o(ewdata), .eraddr_o(eraddr),
    .erdata_i(erdata), .valid_o, .ready_i, .entry_index_o, .is_new_o,
    .table_full_o, .direction_o, .stored_count_o, .count_up_o, .count_down_o,
    .count_left_o, .count_right_o, .count_rest_o
  );
endmodule

>>> hw/rtl/rdt_ram.sv
// generic single write port ram with registered read
module rdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hw/rtl/rdt_front.sv
// front end: collects report bytes into a two-slot buffer and classifies direction
module rdt_front import rdt_pkg::*; #(
  parameter int unsigned MaxBytes = 65
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [DataW-1:0]              report_byte_i,
  input  logic                          final_byte_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [DataW-1:0]              axis_center_i,
  input  logic [DataW-1:0]              dead_zone_i,
  // buffer write
  output logic                          bwe_o,
  output logic [$clog2(2*MaxBytes)-1:0] bwaddr_o,
  output logic [DataW-1:0]              bwdata_o,
  // queue to back end
  output logic                          qvalid_o,
  input  logic                          qpop_i,
  output logic                          qslot_o,
  output logic [$clog2(MaxBytes+1)-1:0] qlen_o,
  output dir_e                          qdir_o
);
  localparam int unsigned LenW = $clog2(MaxBytes + 1);
  localparam int unsigned AddrW = $clog2(2 * MaxBytes);

  logic [LenW-1:0]  len_q, len_d;
  logic             wslot_q, rslot_q;
  logic [1:0]       cnt_q;
  logic [DataW-1:0] b1_q, b2_q;
  logic [LenW-1:0]  qlen_q [2];
  dir_e             qdir_q [2];
  logic             acc, push, keep;
  logic [LenW-1:0]  nlen;

  assign ready_o = (cnt_q != 2'd2);
  assign acc = valid_i && ready_o;
  assign keep = acc && (len_q < LenW'(MaxBytes));
  assign push = acc && final_byte_i;
  assign nlen = keep ? len_q + 1'b1 : len_q;

  assign bwe_o = keep;
  assign bwaddr_o = wslot_q ? AddrW'(MaxBytes) + AddrW'(len_q) : AddrW'(len_q);
  assign bwdata_o = report_byte_i;

  always_comb begin
    len_d = len_q;
    if (acc) len_d = final_byte_i ? '0 : nlen;
  end

  assign qvalid_o = (cnt_q != 2'd0);
  assign qslot_o = rslot_q;
  assign qlen_o = qlen_q[rslot_q];
  assign qdir_o = qdir_q[rslot_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      wslot_q <= 1'b0;
      rslot_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      len_q <= len_d;
      if (push) wslot_q <= ~wslot_q;
      if (qpop_i) rslot_q <= ~rslot_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, qpop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep && len_q == LenW'(1)) b1_q <= report_byte_i;
    if (keep && len_q == LenW'(2)) b2_q <= report_byte_i;
    if (push) begin
      qlen_q[wslot_q] <= nlen;
      qdir_q[wslot_q] <= classify(b1_q, (keep && len_q == LenW'(2)) ? report_byte_i : b2_q,
                                  axis_center_i, dead_zone_i, nlen < LenW'(3));
    end
  end
endmodule

>>> hw/rtl/rdt_back.sv
// back end: scans the table byte by byte, stores new reports, keeps the counts
module rdt_back import rdt_pkg::*; #(
  parameter int unsigned Entries = 64,
  parameter int unsigned MaxBytes = 65
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  qvalid_i,
  output logic                                  qpop_o,
  input  logic                                  qslot_i,
  input  logic [$clog2(MaxBytes+1)-1:0]         qlen_i,
  input  dir_e                                  qdir_i,
  output logic [$clog2(2*MaxBytes)-1:0]         braddr_o,
  input  logic [DataW-1:0]                      brdata_i,
  output logic                                  ewe_o,
  output logic [$clog2(Entries*MaxBytes)-1:0]   ewaddr_o,
  output logic [DataW-1:0]                      ewdata_o,
  output logic [$clog2(Entries*MaxBytes)-1:0]   eraddr_o,
  input  logic [DataW-1:0]                      erdata_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [5:0]                            entry_index_o,
  output logic                                  is_new_o,
  output logic                                  table_full_o,
  output logic [2:0]                            direction_o,
  output logic [CountW-1:0]                     stored_count_o,
  output logic [CountW-1:0]                     count_up_o,
  output logic [CountW-1:0]                     count_down_o,
  output logic [CountW-1:0]                     count_left_o,
  output logic [CountW-1:0]                     count_right_o,
  output logic [CountW-1:0]                     count_rest_o
);
  localparam int unsigned LenW = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned UsedW = $clog2(Entries + 1);
  localparam int unsigned BAddrW = $clog2(2 * MaxBytes);
  localparam int unsigned EAddrW = $clog2(Entries * MaxBytes);

  back_state_e state_q, state_d;
  logic [UsedW-1:0] used_q;
  logic [IdxW-1:0]  ent_q, ent_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic             rdv_q;
  logic [LenW-1:0]  elen_rd;
  logic [UsedW-1:0] cup_q, cdn_q, clf_q, crt_q, crs_q;
  logic             match, mism, last_ent, new_ent, full;

  assign braddr_o = (qslot_i ? BAddrW'(MaxBytes) : BAddrW'(0)) + BAddrW'(pos_q);
  assign eraddr_o = EAddrW'(ent_q) * EAddrW'(MaxBytes) + EAddrW'(pos_q);
  assign mism = rdv_q && (brdata_i != erdata_i);
  assign last_ent = (UsedW'(ent_q) + 1'b1 >= used_q);
  assign full = (used_q == UsedW'(Entries));

  always_comb begin
    state_d = state_q;
    ent_d = ent_q;
    pos_d = pos_q;
    match = 1'b0;
    new_ent = 1'b0;
    unique case (state_q)
      ST_IDLE: if (qvalid_i) begin
        ent_d = '0;
        pos_d = '0;
        state_d = (used_q == '0) ? (full ? ST_RESULT : ST_COPY) : ST_SCAN;
      end
      ST_SCAN: begin
        pos_d = '0;
        if (elen_rd == qlen_i) begin
          state_d = ST_CMP;
          pos_d = LenW'(1);
        end
        else if (last_ent) state_d = full ? ST_RESULT : ST_COPY;
        else ent_d = ent_q + 1'b1;
      end
      ST_CMP: begin
        if (mism) begin
          pos_d = '0;
          if (last_ent) state_d = full ? ST_RESULT : ST_COPY;
          else begin
            ent_d = ent_q + 1'b1;
            state_d = ST_SCAN;
          end
        end else if (pos_q == qlen_i) begin
          match = 1'b1;
          state_d = ST_RESULT;
        end else pos_d = pos_q + 1'b1;
      end
      ST_COPY: begin
        ent_d = IdxW'(used_q);
        if (rdv_q && pos_q == qlen_i) begin
          new_ent = 1'b1;
          state_d = ST_RESULT;
        end else if (pos_q < qlen_i) pos_d = pos_q + 1'b1;
      end
      ST_RESULT: if (!valid_o || ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // entry lengths, read address is ent_d so the registered read data lines up with ent_q
  rdt_ram #(.Width(LenW), .Depth(Entries)) u_len (
    .clk_i, .we_i(new_ent), .waddr_i(IdxW'(used_q)), .wdata_i(qlen_i),
    .raddr_i(ent_d), .rdata_o(elen_rd)
  );

  assign qpop_o = (state_q == ST_RESULT) && (!valid_o || ready_i);
  assign ewe_o = (state_q == ST_COPY) && rdv_q;
  assign ewaddr_o = EAddrW'(used_q) * EAddrW'(MaxBytes) + EAddrW'(pos_q - 1'b1);
  assign ewdata_o = brdata_i;

  logic matched_q, new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q <= '0;
      ent_q <= '0;
      pos_q <= '0;
      rdv_q <= 1'b0;
      cup_q <= '0; cdn_q <= '0; clf_q <= '0; crt_q <= '0; crs_q <= '0;
      valid_o <= 1'b0;
      matched_q <= 1'b0;
      new_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ent_q <= ent_d;
      pos_q <= pos_d;
      // data next cycle holds byte pos_q of an in-order read
      rdv_q <= (state_d == ST_CMP || (state_d == ST_COPY && state_q == ST_COPY))
               && (pos_q < qlen_i);
      if (state_q == ST_IDLE) begin
        matched_q <= 1'b0;
        new_q <= 1'b0;
      end
      if (match) matched_q <= 1'b1;
      if (new_ent) begin
        new_q <= 1'b1;
        used_q <= used_q + 1'b1;
        case (qdir_i)
          DIR_UP: cup_q <= cup_q + 1'b1;
          DIR_DOWN: cdn_q <= cdn_q + 1'b1;
          DIR_LEFT: clf_q <= clf_q + 1'b1;
          DIR_RIGHT: crt_q <= crt_q + 1'b1;
          default: crs_q <= crs_q + 1'b1;
        endcase
      end
      valid_o <= qpop_o || (valid_o && !ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (qpop_o) begin
      entry_index_o <= (matched_q || new_q) ? 6'(ent_q) : 6'd0;
      is_new_o <= new_q;
      table_full_o <= !matched_q && !new_q;
      direction_o <= qdir_i;
      stored_count_o <= CountW'(used_q);
      count_up_o <= CountW'(cup_q);
      count_down_o <= CountW'(cdn_q);
      count_left_o <= CountW'(clf_q);
      count_right_o <= CountW'(crt_q);
      count_rest_o <= CountW'(crs_q);
    end
  end
endmodule

>>> dv/tb_report_dedup_table_with_direction.sv
// testbench for the report dedup table: directed table then random reports, checked by a predictor
module tb_report_dedup_table_with_direction;
  import rdt_pkg::*;

  localparam int unsigned Entries = 64;
  localparam int unsigned MaxBytes = 65;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [5:0] entry_index;
    logic       is_new;
    logic       table_full;
    logic [2:0] direction;
    logic [6:0] stored_count;
    logic [6:0] count_up;
    logic [6:0] count_down;
    logic [6:0] count_left;
    logic [6:0] count_right;
    logic [6:0] count_rest;
  } summary_t;

  logic       clk_i, rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       valid_i, ready_o, final_byte_i, valid_o, ready_i;
  logic [7:0] report_byte_i;
  summary_t   seen;

  report_dedup_table_with_direction u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .valid_i, .ready_o, .report_byte_i, .final_byte_i,
    .valid_o, .ready_i,
    .entry_index_o(seen.entry_index), .is_new_o(seen.is_new),
    .table_full_o(seen.table_full), .direction_o(seen.direction),
    .stored_count_o(seen.stored_count), .count_up_o(seen.count_up),
    .count_down_o(seen.count_down), .count_left_o(seen.count_left),
    .count_right_o(seen.count_right), .count_rest_o(seen.count_rest)
  );

  // predictor state
  logic [7:0] center_q, dead_q;
  logic [7:0] pend_bytes [MaxBytes];
  int         pend_len;
  logic [7:0] slot_bytes [Entries][MaxBytes];
  int         slot_len [Entries];
  int         slots_used;
  int         dir_count [5];

  summary_t   pending_summaries [$];
  int         errors;
  int         cycles;
  bit         quiet;
  bit         hold_req;

  // history of sent reports for repeats
  logic [7:0] hist_bytes [256][80];
  int         hist_len [256];
  int         hist_n;

  // directed table
  localparam int NDir = 19;
  logic [7:0] d_byte [NDir] = '{8'h00,
                                8'h00, 8'h80, 8'h80,
                                8'h00, 8'hff, 8'h80,
                                8'h00, 8'h00, 8'h80,
                                8'h00, 8'h80, 8'hff,
                                8'h00, 8'h80, 8'h00,
                                8'h00,
                                8'hff, 8'hff};
  bit         d_fin [NDir] = '{1, 0,0,1, 0,0,1, 0,0,1, 0,0,1, 0,0,1, 1, 0,1};
  int         d_idx [NDir] = '{0, 0,0,1, 0,0,2, 0,0,3, 0,0,4, 0,0,5, 0, 0,6};
  bit         d_new [NDir] = '{1, 0,0,1, 0,0,1, 0,0,1, 0,0,1, 0,0,1, 0, 0,1};
  dir_e       d_dir [NDir] = '{DIR_UNKNOWN, DIR_NEUTRAL, DIR_NEUTRAL, DIR_NEUTRAL,
                               DIR_RIGHT, DIR_RIGHT, DIR_RIGHT, DIR_LEFT, DIR_LEFT,
                               DIR_LEFT, DIR_DOWN, DIR_DOWN, DIR_DOWN, DIR_UP, DIR_UP,
                               DIR_UP, DIR_UNKNOWN, DIR_UNKNOWN, DIR_UNKNOWN};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_report_dedup_table_with_direction: FAIL");
      $finish;
    end
  end

  function automatic dir_e direction_of(int len);
    int ax, ay;
    if (len < 3) return DIR_UNKNOWN;
    ax = (pend_bytes[1] >= center_q) ? pend_bytes[1] - center_q : center_q - pend_bytes[1];
    ay = (pend_bytes[2] >= center_q) ? pend_bytes[2] - center_q : center_q - pend_bytes[2];
    if (ax < dead_q && ay < dead_q) return DIR_NEUTRAL;
    if (ax > ay) return (pend_bytes[1] > center_q) ? DIR_RIGHT : DIR_LEFT;
    return (pend_bytes[2] > center_q) ? DIR_DOWN : DIR_UP;
  endfunction

  // absorb one accepted byte; returns 1 with a summary when a report closes
  task automatic absorb_byte(input logic [7:0] b, input bit fin, output bit done,
                             output summary_t s);
    int   len, hit;
    bit   same;
    dir_e d;
    done = 0;
    s = '0;
    if (pend_len < MaxBytes) begin
      pend_bytes[pend_len] = b;
      pend_len++;
    end
    if (!fin) return;
    done = 1;
    len = pend_len;
    pend_len = 0;
    hit = -1;
    for (int i = 0; i < slots_used && hit < 0; i++) begin
      if (slot_len[i] == len) begin
        same = 1;
        for (int k = 0; k < len; k++) if (slot_bytes[i][k] != pend_bytes[k]) same = 0;
        if (same) hit = i;
      end
    end
    d = direction_of(len);
    s.direction = d;
    if (hit >= 0) begin
      s.entry_index = 6'(hit);
    end else if (slots_used < Entries) begin
      s.entry_index = 6'(slots_used);
      for (int k = 0; k < len; k++) slot_bytes[slots_used][k] = pend_bytes[k];
      slot_len[slots_used] = len;
      slots_used++;
      dir_count[(d == DIR_UNKNOWN) ? int'(DIR_NEUTRAL) : int'(d)]++;
      s.is_new = 1;
    end else begin
      s.table_full = 1;
    end
    s.stored_count = 7'(slots_used);
    s.count_up = 7'(dir_count[DIR_UP]);
    s.count_down = 7'(dir_count[DIR_DOWN]);
    s.count_left = 7'(dir_count[DIR_LEFT]);
    s.count_right = 7'(dir_count[DIR_RIGHT]);
    s.count_rest = 7'(dir_count[DIR_NEUTRAL]);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit fin, output bit done,
                           output summary_t s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    report_byte_i <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!ready_o);
    absorb_byte(b, fin, done, s);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_AXIS_CENTER) center_q = v;
    else dead_q = v;
  endtask

  task automatic drain;
    valid_i <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_random_report(inout int sent);
    int       len, h;
    bit       done;
    summary_t s;
    logic [7:0] buf_b [80];
    if (hist_n > 0 && $urandom_range(0, 2) == 0) begin
      h = $urandom_range(0, hist_n - 1);
      len = hist_len[h];
      for (int k = 0; k < len; k++) buf_b[k] = hist_bytes[h][k];
    end else begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(63, 72) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
        buf_b[k] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                        : 8'(center_q + $urandom_range(0, 60) - 30);
      if (hist_n < 256) begin
        for (int k = 0; k < len; k++) hist_bytes[hist_n][k] = buf_b[k];
        hist_len[hist_n] = len;
        hist_n++;
      end
    end
    for (int k = 0; k < len; k++) begin
      send_byte(buf_b[k], k == len - 1, done, s);
      if (done) pending_summaries.push_back(s);
    end
    sent += len;
  endtask

  // result side: random stalls and one long hold-off
  initial begin
    ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      if (pending_summaries.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: %p", seen);
      end else begin
        if (seen !== pending_summaries[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p actual %p", pending_summaries[0], seen);
        end
        void'(pending_summaries.pop_front());
      end
    end
  end

  initial begin
    bit         done;
    summary_t   s;
    logic [7:0] phase_center [4];
    logic [7:0] phase_dead [4];
    int         sent;
    phase_center = '{8'd128, 8'd0, 8'd255, 8'd0};
    phase_dead = '{8'd15, 8'd0, 8'd255, 8'd0};
    errors = 0;
    cycles = 0;
    quiet = 0;
    hold_req = 0;
    hist_n = 0;
    pend_len = 0;
    slots_used = 0;
    for (int i = 0; i < 5; i++) dir_count[i] = 0;
    center_q = 8'd128;
    dead_q = 8'd15;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_AXIS_CENTER;
    cfg_data_i = 8'd0;
    valid_i = 1'b0;
    report_byte_i = 8'd0;
    final_byte_i = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NDir; r++) begin
      send_byte(d_byte[r], d_fin[r], done, s);
      if (done) begin
        s.entry_index = 6'(d_idx[r]);
        s.is_new = d_new[r];
        s.table_full = 1'b0;
        s.direction = d_dir[r];
        pending_summaries.push_back(s);
      end
    end
    drain();

    phase_center[3] = $urandom_range(0, 255);
    phase_dead[3] = $urandom_range(1, 254);
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_AXIS_CENTER, phase_center[p]);
      write_reg(REG_DEAD_ZONE, phase_dead[p]);
      if (p == 3) quiet = 1;
      if (p == 1) hold_req = 1;
      sent = 0;
      while (sent < 370) send_random_report(sent);
      drain();
    end

    if (errors == 0) $display("tb_report_dedup_table_with_direction: PASS");
    else $display("tb_report_dedup_table_with_direction: FAIL");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/rdt_pkg.sv
hw/rtl/rdt_ram.sv
hw/rtl/rdt_front.sv
hw/rtl/rdt_back.sv
hw/rtl/report_dedup_table_with_direction.sv
dv/tb_report_dedup_table_with_direction.sv
